[sv/assert_macros.svh]
// Assertion macros used by the top level of the rotated box decoder.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define RBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define RBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/rbd_pkg.sv]
// Types and constants of the rotated box decoder.
// No dependencies; used by every module of the block.
package rbd_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ZW = 20;   // CORDIC x, y and residual angle width
    localparam int QUEUE_DEPTH = 4;
    localparam int QAW = 2;   // queue address width

    localparam logic [15:0]      THRESH_RESET    = 16'd32768;
    localparam logic signed [19:0] CORDIC_START  = 20'sd39797;
    localparam logic signed [19:0] PI_Q16        = 20'sd205887;
    localparam logic signed [19:0] HALF_PI_Q16   = 20'sd102944;
    localparam logic signed [23:0] DEG_PER_RAD   = 24'sd3754936;

    localparam logic signed [ZW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
        20'sd8, 20'sd4, 20'sd2
    };

    // One classified cell waiting for the rotation back end.
    typedef struct packed {
        logic [7:0]          col;
        logic [7:0]          row;
        logic signed [16:0]  dh;
        logic signed [16:0]  dv;
        logic [16:0]         width;
        logic [16:0]         height;
        logic signed [15:0]  deg;
        logic [15:0]         score;
        logic signed [ZW-1:0] z;
        logic                flip;
    } t_item;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[sv/rbd_front.sv]
// Front end: score threshold register, cell classification and clamping,
// box size sums, degree conversion and angle folding. Uses rbd_pkg.
module rbd_front #(
    parameter int MAX_MAP_DIM = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [15:0]     i_cfg_wr_data,
    input  logic            i_valid,
    input  logic [111:0]    i_data,
    input  rbd_pkg::t_q_status i_q_status,
    output logic            o_ready,
    output logic            o_push,
    output rbd_pkg::t_item  o_item
);
    import rbd_pkg::*;

    logic [15:0] r_thresh;
    logic [7:0]  col, row;
    logic [15:0] score, top, right, bottom, left;
    logic signed [15:0] ang;
    logic signed [40:0] deg_prod;
    logic signed [40:0] deg_sh;
    logic signed [ZW-1:0] z8;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_thresh <= i_cfg_wr_data;
        end
    end

    assign col    = i_data[7:0];
    assign row    = i_data[15:8];
    assign score  = i_data[31:16];
    assign top    = i_data[47:32];
    assign right  = i_data[63:48];
    assign bottom = i_data[79:64];
    assign left   = i_data[95:80];
    assign ang    = i_data[111:96];

    // Requests are taken whenever the queue has room; low scores are dropped.
    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready && (score >= r_thresh);

    // Classification and per-cell arithmetic.
    always_comb begin
        o_item.col = ({5'd0, col} >= 13'(MAX_MAP_DIM)) ? 8'(MAX_MAP_DIM - 1) : col;
        o_item.row = ({5'd0, row} >= 13'(MAX_MAP_DIM)) ? 8'(MAX_MAP_DIM - 1) : row;
        o_item.dh     = $signed({1'b0, right}) - $signed({1'b0, left});
        o_item.dv     = $signed({1'b0, bottom}) - $signed({1'b0, top});
        o_item.width  = {1'b0, right} + {1'b0, left};
        o_item.height = {1'b0, top} + {1'b0, bottom};
        o_item.score  = score;

        // Negated angle in degrees, rounded half up, saturated.
        deg_prod = -(41'(ang)) * 41'(DEG_PER_RAD);
        deg_sh   = (deg_prod + 41'sd2097152) >>> 22;
        if (deg_sh > 41'sd32767) begin
            o_item.deg = 16'sh7fff;
        end else if (deg_sh < -41'sd32768) begin
            o_item.deg = 16'sh8000;
        end else begin
            o_item.deg = deg_sh[15:0];
        end

        // Fold the angle into the CORDIC's range.
        z8 = ZW'(ang) <<< 3;
        priority if (z8 > HALF_PI_Q16) begin
            o_item.z    = z8 - PI_Q16;
            o_item.flip = 1'b1;
        end else if (z8 < -HALF_PI_Q16) begin
            o_item.z    = z8 + PI_Q16;
            o_item.flip = 1'b1;
        end else begin
            o_item.z    = z8;
            o_item.flip = 1'b0;
        end
    end

endmodule

[sv/rbd_queue.sv]
// Short queue between front and back ends of the box decoder.
// Uses rbd_pkg for the item type and depth.
module rbd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rbd_pkg::t_item     i_item,
    input  logic               i_pop,
    output rbd_pkg::t_item     o_item,
    output rbd_pkg::t_q_status o_status
);
    import rbd_pkg::*;

    t_item          r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_item         = r_mem[r_rp];
    assign o_status.full  = (r_cnt == (QAW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

[sv/rbd_back.sv]
// Back end: pipelined 16-step CORDIC, center products, rounding and
// saturation, and the output register. Uses rbd_pkg.
module rbd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbd_pkg::t_item     i_item,
    input  rbd_pkg::t_q_status i_q_status,
    output logic               o_pop,
    input  logic               i_tready,
    output logic               o_tvalid,
    output logic [111:0]       o_tdata
);
    import rbd_pkg::*;

    localparam int NS = CORDIC_STEPS + 2;   // CORDIC input, steps, product stage

    logic                 r_vld [NS];
    t_item                r_it  [NS];
    logic signed [ZW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [ZW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] r_z [CORDIC_STEPS+1];
    logic signed [36:0]   r_m_cdh, r_m_sdv, r_m_cdv, r_m_sdh;
    logic                 r_o_vld;
    logic [111:0]         r_o_data;
    logic                 en;
    logic signed [ZW-1:0] c, s;
    logic signed [38:0]   sum_x, sum_y;
    logic signed [39:0]   cx, cy;

    function automatic logic signed [19:0] sat20(input logic signed [39:0] v);
        if (v > 40'sd524287)       return 20'sh7ffff;
        else if (v < -40'sd524288) return 20'sh80000;
        else                       return v[19:0];
    endfunction

    // The whole pipe moves when the output register is free or being taken.
    assign en    = !r_o_vld || i_tready;
    assign o_pop = en && !i_q_status.empty;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vld[k] <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_vld[0] <= !i_q_status.empty;
            for (int k = 1; k < NS; k++) r_vld[k] <= r_vld[k-1];
            r_o_vld <= r_vld[NS-1];
        end
    end

    // Item payload carried alongside, and the CORDIC start values.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it[0] <= i_item;
            for (int k = 1; k < NS; k++) r_it[k] <= r_it[k-1];
            r_x[0] <= CORDIC_START;
            r_y[0] <= '0;
            r_z[0] <= i_item.z;
        end
    end

    // One CORDIC rotation per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [ZW-1:0] dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - ATAN_Q16[i];
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + ATAN_Q16[i];
                end
            end
        end
    end

    // Quadrant correction and the four products.
    assign c = r_it[CORDIC_STEPS].flip ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
    assign s = r_it[CORDIC_STEPS].flip ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_cdh <= 37'(c) * 37'(r_it[CORDIC_STEPS].dh);
            r_m_sdv <= 37'(s) * 37'(r_it[CORDIC_STEPS].dv);
            r_m_cdv <= 37'(c) * 37'(r_it[CORDIC_STEPS].dv);
            r_m_sdh <= 37'(s) * 37'(r_it[CORDIC_STEPS].dh);
        end
    end

    // Halve with round half up, add the stride offset, saturate.
    always_comb begin
        sum_x = 39'(r_m_cdh) + 39'(r_m_sdv) + 39'sd65536;
        sum_y = 39'(r_m_cdv) - 39'(r_m_sdh) + 39'sd65536;
        cx = 40'(sum_x >>> 17) + $signed({26'd0, r_it[NS-1].col, 6'd0});
        cy = 40'(sum_y >>> 17) + $signed({26'd0, r_it[NS-1].row, 6'd0});
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= {6'd0, r_it[NS-1].score, r_it[NS-1].deg, r_it[NS-1].height,
                         r_it[NS-1].width, sat20(cy), sat20(cx)};
        end
    end

    assign o_tvalid = r_o_vld;
    assign o_tdata  = r_o_data;

endmodule

[sv/rotated_box_decoder.sv]
// Top level of the rotated box decoder: front end, queue, back end.
// Uses rbd_pkg, rbd_front, rbd_queue, rbd_back and assert_macros.svh.
//
// Cells arrive on the s_axis channel, one request per cycle at most. A cell
// whose score is below the threshold register is dropped; any other cell
// gives one rotated box on the m_axis channel, in arrival order.
// The threshold is written through i_cfg_wr_en / i_cfg_wr_data and reads
// 32768 after reset.
// Throughput: one cell per cycle while m_axis_tready is high.
// Path: an accepted cell reaches m_axis through the queue storage, the
// CORDIC input register, the 16-stage CORDIC, the product stage and the
// output register.
// When the receiver stalls, the back-end pipeline holds, the four-entry
// queue fills, and s_axis_tready drops only when the queue is full.
// Reset (synchronous, active low) empties the queue and the pipeline and
// restores the threshold.
`include "assert_macros.svh"
module rotated_box_decoder #(
    parameter int MAX_MAP_DIM = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cell_col, cell_row, score, dist_top, dist_right, dist_bottom,
    // dist_left, angle_rad
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // center_x, center_y, box_width, box_height, angle_deg, confidence, pad
    output logic [111:0] m_axis_tdata
);
    import rbd_pkg::*;

    t_item     w_f_item, w_q_item;
    t_q_status w_q_status;
    logic      w_push, w_pop;

    rbd_front #(.MAX_MAP_DIM(MAX_MAP_DIM)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(s_axis_tvalid), .i_data(s_axis_tdata),
        .i_q_status(w_q_status), .o_ready(s_axis_tready),
        .o_push(w_push), .o_item(w_f_item)
    );

    rbd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_item(w_f_item),
        .i_pop(w_pop), .o_item(w_q_item), .o_status(w_q_status)
    );

    rbd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(w_q_item), .i_q_status(w_q_status), .o_pop(w_pop),
        .i_tready(m_axis_tready), .o_tvalid(m_axis_tvalid), .o_tdata(m_axis_tdata)
    );

    // Queue never written when full nor read when empty.
    `RBD_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, w_push, !w_q_status.full)
    `RBD_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, w_pop, !w_q_status.empty)
    // A push needs a request taken on s_axis, so a full queue never pushes.
    `RBD_ASSERT_NOW(a_push_needs_req, i_clk, i_rst_n, w_push, s_axis_tvalid && s_axis_tready)
    // A push into an empty queue leaves it non-empty when nothing pops.
    `RBD_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, w_push && !w_pop, !w_q_status.empty)

endmodule

[bench/testbench.sv]
// Self-checking testbench for the rotated box decoder.
// Depends only on the RTL top, rotated_box_decoder; drives cells, predicts boxes.
`timescale 1ns / 100ps

module testbench;

    localparam int MAP_DIM   = 256;
    localparam int WATCHDOG  = 20000;
    localparam int DRAIN     = 40;
    localparam int N_RANDOM  = 2000;

    // One decoded box as the block reports it, last field in the lowest bits.
    typedef struct packed {
        logic [15:0]        conf;
        logic signed [15:0] deg;
        logic [16:0]        height;
        logic [16:0]        width;
        logic signed [19:0] cy;
        logic signed [19:0] cx;
    } t_box;

    typedef struct {
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] score;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [15:0] left;
        logic [15:0] ang;
    } t_cell;

    // Predicts boxes for accepted cells and checks the block's output against them.
    class t_box_scoreboard;
        logic [15:0] threshold;
        t_box        pending[$];
        int          errors;
        int          boxes_checked;

        function new();
            threshold = 16'd32768;
            errors = 0;
            boxes_checked = 0;
        endfunction

        static function longint fshift(longint v, int n);
            return v >>> n;
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // Rotation-mode CORDIC with the angle folded into the right half-plane.
        static function void rotate(longint ang, output longint s, output longint c);
            longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2};
            longint z, x, y, dx, dy;
            bit flip;
            z = ang * 8;
            x = 39797;
            y = 0;
            flip = 0;
            if (z > 102944) begin
                z -= 205887;
                flip = 1;
            end else if (z < -102944) begin
                z += 205887;
                flip = 1;
            end
            for (int i = 0; i < 16; i++) begin
                dx = fshift(y, i);
                dy = fshift(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end else begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            s = y;
            c = x;
        endfunction

        function void note_cell(t_cell k);
            longint col, row, ang, s, c, dh, dv, cx, cy, deg;
            t_box b;
            if (k.score < threshold) return;
            col = k.col;
            row = k.row;
            if (col > MAP_DIM - 1) col = MAP_DIM - 1;
            if (row > MAP_DIM - 1) row = MAP_DIM - 1;
            ang = longint'($signed(k.ang));
            rotate(ang, s, c);
            dh = longint'(k.right) - longint'(k.left);
            dv = longint'(k.bottom) - longint'(k.top);
            cx = col * 64 + fshift(c * dh + s * dv + 65536, 17);
            cy = row * 64 + fshift(c * dv - s * dh + 65536, 17);
            deg = fshift(-ang * 3754936 + (longint'(1) << 21), 22);
            b.cx = 20'(clamp(cx, -524288, 524287));
            b.cy = 20'(clamp(cy, -524288, 524287));
            b.width = 17'(longint'(k.right) + longint'(k.left));
            b.height = 17'(longint'(k.top) + longint'(k.bottom));
            b.deg = 16'(clamp(deg, -32768, 32767));
            b.conf = k.score;
            pending.insert(pending.size(), b);
        endfunction

        function void check_box(t_box got);
            t_box want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected box, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            boxes_checked++;
            if (got.cx !== want.cx) begin
                $display("%0t: center_x expected %0d actual %0d", $time, want.cx, got.cx);
                errors++;
            end
            if (got.cy !== want.cy) begin
                $display("%0t: center_y expected %0d actual %0d", $time, want.cy, got.cy);
                errors++;
            end
            if (got.width !== want.width) begin
                $display("%0t: box_width expected %0d actual %0d", $time, want.width,
                         got.width);
                errors++;
            end
            if (got.height !== want.height) begin
                $display("%0t: box_height expected %0d actual %0d", $time, want.height,
                         got.height);
                errors++;
            end
            if (got.deg !== want.deg) begin
                $display("%0t: angle_deg expected %0d actual %0d", $time, want.deg, got.deg);
                errors++;
            end
            if (got.conf !== want.conf) begin
                $display("%0t: confidence expected %0d actual %0d", $time, want.conf,
                         got.conf);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [15:0]  i_cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;

    t_box_scoreboard board;
    int  idle_cycles;
    int  cells_sent;
    int  thresholds_used;
    bit  stim_done;

    rotated_box_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_field();
        unique case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends one cell request and waits until it is taken. The valid line stays
    // high afterwards, so back-to-back requests leave no gap in it.
    task automatic send_cell(t_cell k);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= {k.ang, k.left, k.bottom, k.right, k.top, k.score, k.row, k.col};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_cell(k);
        cells_sent++;
        @(negedge i_clk);
    endtask

    // Waits for every box to arrive, lets the pipeline empty, then writes the threshold.
    task automatic write_threshold(logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.threshold = value;
        thresholds_used++;
    endtask

    task automatic send_random(int count, bit wide_angles);
        t_cell k;
        for (int i = 0; i < count; i++) begin
            k.col = 8'($urandom);
            k.row = 8'($urandom);
            k.score = ($urandom_range(0, 3) == 0) ? rand_field() : 16'($urandom);
            k.top = rand_field();
            k.right = rand_field();
            k.bottom = rand_field();
            k.left = rand_field();
            k.ang = wide_angles ? 16'($urandom)
                                : 16'($signed($urandom_range(0, 25736)) - 12868);
            send_cell(k);
        end
    endtask

    // Receiver: random stalls, checks each box taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_box(t_box'(m_axis_tdata[105:0]));
        end
    end

    // Watchdog on cycles with no request moving on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        t_cell k;
        board = new();
        idle_cycles = 0;
        cells_sent = 0;
        thresholds_used = 0;
        stim_done = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: threshold edges around the reset value.
        k = '{8'd10, 8'd20, 16'd32767, 16'd64, 16'd64, 16'd64, 16'd64, 16'd0};
        send_cell(k);
        k.score = 16'd32768;
        send_cell(k);
        // Field extremes, corner angles and cells at the map border.
        k = '{8'd0, 8'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        send_cell(k);
        k = '{8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF};
        send_cell(k);
        k = '{8'd255, 8'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'h8000};
        send_cell(k);
        k = '{8'd0, 8'd255, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'h8000};
        send_cell(k);
        k = '{8'd255, 8'd255, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd12868};
        send_cell(k);
        k = '{8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hCDBC};
        send_cell(k);
        // Angles just beyond a quarter turn and near a half turn exercise the half-plane fold.
        k = '{8'd128, 8'd64, 16'h9000, 16'd300, 16'd500, 16'd700, 16'd100, 16'd12869};
        send_cell(k);
        k.ang = 16'($signed(-16'sd12869));
        send_cell(k);
        k.ang = 16'd25736;
        send_cell(k);
        k.ang = 16'($signed(-16'sd25736));
        send_cell(k);
        k.score = 16'd0;
        send_cell(k);

        // Random cells over several thresholds, extremes included.
        send_random(400, 1);
        write_threshold(16'd0);
        send_random(400, 0);
        write_threshold(16'hFFFF);
        send_random(200, 1);
        k = '{8'd1, 8'd2, 16'hFFFF, 16'd5, 16'd6, 16'd7, 16'd8, 16'd100};
        send_cell(k);
        write_threshold(16'($urandom));
        send_random(500, 1);
        write_threshold(16'd1);
        send_random(N_RANDOM - 1500, 0);

        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("Sent %0d cells under %0d threshold settings; checked %0d boxes.",
                 cells_sent, thresholds_used + 1, board.boxes_checked);
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/rbd_pkg.sv
sv/rbd_front.sv
sv/rbd_queue.sv
sv/rbd_back.sv
sv/rotated_box_decoder.sv
bench/testbench.sv
